// ----- hdl/igmp_pkg.sv -----
// shared types and constants of the igmp message parser
package igmp_pkg;

  localparam int unsigned LenBitsDefault = 16;
  localparam int unsigned HdrBytes       = 8;
  localparam int unsigned WordBytes      = 4;
  localparam int unsigned CfgIdxBits     = 1;
  localparam int unsigned CfgDataBits    = 8;

  localparam logic [7:0] QueryCodeReset    = 8'd17;
  localparam logic [7:0] ReportV3CodeReset = 8'd34;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_QUERY_CODE     = 1'b0,
    CFG_REPORT_V3_CODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR  = 3'd1,
    PH_QEXT = 3'd2,
    PH_QSRC = 3'd3,
    PH_REC  = 3'd4,
    PH_RSRC = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HDR  = 3'd0,
    KIND_QEXT = 3'd1,
    KIND_REC  = 3'd2,
    KIND_SRC  = 3'd3,
    KIND_END  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_QSRC      = 3'd2,
    ST_GCOUNT    = 3'd3,
    ST_RSRC      = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] query_code;
    logic [7:0] report_v3_code;
  } cfg_t;

  typedef struct packed {
    logic [15:0] packet_length;
    logic        first_byte;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       item_kind;
    logic [7:0]  msg_type;
    logic [7:0]  resp_time;
    logic [15:0] checksum;
    logic [31:0] address;
    logic [15:0] entry_count;
    logic [7:0]  flags_or_record_type;
    logic [7:0]  code_or_aux_len;
    logic [15:0] record_number;
    logic        packet_done;
    status_e     status;
  } out_item_t;

endpackage

// ----- hdl/igmp_in_stage.sv -----
// input register stage holding one byte transfer for the parser
module igmp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  igmp_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              take_i,
  output igmp_pkg::in_item_t item_o
);
  import igmp_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- hdl/igmp_parse_core.sv -----
// per-byte parse state update and registered result item
module igmp_parse_core #(
  parameter int unsigned LENGTH_BITS = igmp_pkg::LenBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  igmp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  igmp_pkg::in_item_t  in_item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output igmp_pkg::out_item_t out_item_o
);
  import igmp_pkg::*;

  localparam int unsigned LenW = LENGTH_BITS;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] bl_q, bl_d;
  logic [2:0]      pos_q, pos_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      resp_q, resp_d;
  logic [15:0]     cksum_q, cksum_d;
  logic [31:0]     sw_q, sw_d;
  logic [15:0]     groups_q, groups_d;
  logic [15:0]     rec_q, rec_d;
  logic [15:0]     src_q, src_d;
  logic [7:0]      flags_q, flags_d;
  logic [7:0]      aux_q, aux_d;

  logic            out_valid_q;
  out_item_t       out_q;
  out_item_t       res;
  logic            emit;

  logic [7:0]      b;
  logic            first;
  logic [LenW-1:0] len;

  assign b     = in_item_i.data_byte;
  assign first = in_item_i.first_byte;
  assign len   = in_item_i.packet_length[LenW-1:0];

  assign take_o      = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic [2:0]      p;
    logic [LenW-1:0] n;
    logic [15:0]     ng;
    logic            nxt;
    phase_d  = phase_q;
    bl_d     = bl_q;
    pos_d    = pos_q;
    type_d   = type_q;
    resp_d   = resp_q;
    cksum_d  = cksum_q;
    sw_d     = sw_q;
    groups_d = groups_q;
    rec_d    = rec_q;
    src_d    = src_q;
    flags_d  = flags_q;
    aux_d    = aux_q;
    emit     = 1'b0;
    res      = '0;
    p        = '0;
    n        = '0;
    ng       = '0;
    nxt      = 1'b0;
    // a first byte drops whatever message was in progress
    if (first) begin
      phase_d  = PH_HDR;
      bl_d     = len;
      pos_d    = '0;
      type_d   = '0;
      resp_d   = '0;
      cksum_d  = '0;
      sw_d     = '0;
      groups_d = '0;
      rec_d    = '0;
      src_d    = '0;
      flags_d  = '0;
      aux_d    = '0;
    end
    if (first && (len < LenW'(HdrBytes))) begin
      phase_d          = PH_IDLE;
      bl_d             = '0;
      emit             = 1'b1;
      res.item_kind    = KIND_END;
      res.packet_done  = 1'b1;
      res.status       = ST_TOO_SHORT;
    end else if (phase_d != PH_IDLE) begin
      if (bl_d != '0) begin
        bl_d = bl_d - LenW'(1);
      end
      sw_d  = {sw_d[23:0], b};
      p     = pos_d;
      pos_d = pos_d + 3'd1;
      n     = bl_d;
      unique case (phase_d)
        PH_HDR: begin
          if (p == 3'd0) type_d = b;
          if (p == 3'd1) resp_d = b;
          if (p == 3'd3) cksum_d = sw_d[15:0];
          if (p == 3'd7) begin
            pos_d         = '0;
            emit          = 1'b1;
            res.item_kind = KIND_HDR;
            if (type_d == cfg_i.report_v3_code) begin
              ng              = sw_d[15:0];
              res.entry_count = ng;
              if ((n != '0) && (ng != '0) && (ng > 16'(n))) begin
                res.packet_done = 1'b1;
                res.status      = ST_GCOUNT;
              end else if ((n >= LenW'(HdrBytes)) && (ng != '0)) begin
                groups_d = ng;
                rec_d    = '0;
                phase_d  = PH_REC;
              end else begin
                res.packet_done = 1'b1;
              end
            end else if (type_d == cfg_i.query_code) begin
              res.address     = sw_d;
              res.packet_done = !(n >= LenW'(WordBytes));
              if (n >= LenW'(WordBytes)) phase_d = PH_QEXT;
            end else begin
              res.address     = sw_d;
              res.packet_done = 1'b1;
            end
          end
        end
        PH_QEXT: begin
          if (p == 3'd0) flags_d = b;
          if (p == 3'd1) aux_d = b;
          if (p == 3'd3) begin
            pos_d                    = '0;
            src_d                    = sw_d[15:0];
            emit                     = 1'b1;
            res.item_kind            = KIND_QEXT;
            res.entry_count          = src_d;
            res.flags_or_record_type = flags_d;
            res.code_or_aux_len      = aux_d;
            if (n < LenW'(WordBytes)) begin
              res.packet_done = 1'b1;
            end else if ({src_d, 2'b00} > 18'(n)) begin
              res.packet_done = 1'b1;
              res.status      = ST_QSRC;
            end else if (src_d == '0) begin
              res.packet_done = 1'b1;
            end else begin
              phase_d = PH_QSRC;
            end
          end
        end
        PH_QSRC: begin
          if (p == 3'd3) begin
            pos_d = '0;
            if (src_d != '0) src_d = src_d - 16'd1;
            emit            = 1'b1;
            res.item_kind   = KIND_SRC;
            res.address     = sw_d;
            res.packet_done = (src_d == '0);
          end
        end
        PH_REC: begin
          if (p == 3'd0) flags_d = b;
          if (p == 3'd1) aux_d = b;
          if (p == 3'd3) src_d = sw_d[15:0];
          if (p == 3'd7) begin
            pos_d = '0;
            if (groups_d != '0) groups_d = groups_d - 16'd1;
            emit                     = 1'b1;
            res.item_kind            = KIND_REC;
            res.address              = sw_d;
            res.entry_count          = src_d;
            res.flags_or_record_type = flags_d;
            res.code_or_aux_len      = aux_d;
            res.record_number        = rec_d;
            if (n < LenW'(WordBytes)) begin
              res.packet_done = 1'b1;
            end else if ({src_d, 2'b00} > 18'(n)) begin
              res.packet_done = 1'b1;
              res.status      = ST_RSRC;
            end else if (src_d != '0) begin
              phase_d = PH_RSRC;
            end else begin
              // record without sources: next record header or end
              nxt             = (groups_d != '0) && (n >= LenW'(HdrBytes));
              res.packet_done = !nxt;
              if (nxt) rec_d = rec_d + 16'd1;
            end
          end
        end
        PH_RSRC: begin
          if (p == 3'd3) begin
            pos_d = '0;
            if (src_d != '0) src_d = src_d - 16'd1;
            emit              = 1'b1;
            res.item_kind     = KIND_SRC;
            res.address       = sw_d;
            res.record_number = rec_d;
            if (src_d == '0) begin
              nxt             = (groups_d != '0) && (n >= LenW'(HdrBytes));
              res.packet_done = !nxt;
              if (nxt) begin
                rec_d   = rec_d + 16'd1;
                phase_d = PH_REC;
              end
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    if (emit) begin
      res.msg_type  = type_d;
      res.resp_time = resp_d;
      res.checksum  = cksum_d;
      if (res.packet_done) phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bl_q     <= '0;
      pos_q    <= '0;
      type_q   <= '0;
      resp_q   <= '0;
      cksum_q  <= '0;
      sw_q     <= '0;
      groups_q <= '0;
      rec_q    <= '0;
      src_q    <= '0;
      flags_q  <= '0;
      aux_q    <= '0;
    end else if (take_o) begin
      phase_q  <= phase_d;
      bl_q     <= bl_d;
      pos_q    <= pos_d;
      type_q   <= type_d;
      resp_q   <= resp_d;
      cksum_q  <= cksum_d;
      sw_q     <= sw_d;
      groups_q <= groups_d;
      rec_q    <= rec_d;
      src_q    <= src_d;
      flags_q  <= flags_d;
      aux_q    <= aux_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_q <= res;
    end
  end

  a_err_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> out_q.packet_done)
    else $error("error status on an item that does not end the message");

  a_end_only_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.item_kind == KIND_END)) |->
      (out_q.status == ST_TOO_SHORT) && out_q.packet_done)
    else $error("end-only item without too-short status");

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (pos_q == 3'd0))
    else $error("field byte position not cleared while idle");

endmodule

// ----- hdl/igmp_message_parser_core.sv -----
// top level of the igmp message parser: ports, config registers, stages
//
// channel   | dir | transfer                          | width
// s_axis    | in  | one message byte, tuser first byte | tdata 24, tuser 1
// m_axis    | out | one parsed item, tlast last item   | tdata 120, tuser 3
// cfg       | in  | type code register write           | idx 1, data 8
//
// one byte per cycle sustained while m_axis is not stalled: a byte goes
// input register -> parse logic -> result register, which drives m_axis.
// reset clears the parse state to idle and the type codes to 17 and 34.
// a stalled result holds the result register; the input register keeps
// accepting until it is full, then s_axis_tready drops.
module igmp_message_parser_core #(
  parameter int unsigned LENGTH_BITS = igmp_pkg::LenBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // data_byte [7:0], packet_length [23:8]
  input  logic [23:0]                          s_axis_tdata,
  // first_byte [0]
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // msg_type, resp_time, checksum, address, entry_count,
  // flags_or_record_type, code_or_aux_len, record_number, status, zero pad
  output logic [119:0]                         m_axis_tdata,
  // item_kind [2:0]
  output logic [2:0]                           m_axis_tuser,
  // packet_done
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [igmp_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [igmp_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import igmp_pkg::*;

  cfg_t      cfg_q;
  in_item_t  in_item;
  in_item_t  st_item;
  logic      st_valid;
  logic      take;
  out_item_t out_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_code     <= QueryCodeReset;
      cfg_q.report_v3_code <= ReportV3CodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_QUERY_CODE:     cfg_q.query_code     <= cfg_data_i;
        CFG_REPORT_V3_CODE: cfg_q.report_v3_code <= cfg_data_i;
      endcase
    end
  end

  assign in_item.data_byte     = s_axis_tdata[7:0];
  assign in_item.packet_length = s_axis_tdata[23:8];
  assign in_item.first_byte    = s_axis_tuser[0];

  igmp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (st_valid),
    .take_i  (take),
    .item_o  (st_item)
  );

  igmp_parse_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (st_valid),
    .in_item_i   (st_item),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {5'b0, 3'(out_item.status), out_item.record_number,
                         out_item.code_or_aux_len, out_item.flags_or_record_type,
                         out_item.entry_count, out_item.address, out_item.checksum,
                         out_item.resp_time, out_item.msg_type};
  assign m_axis_tuser = 3'(out_item.item_kind);
  assign m_axis_tlast = out_item.packet_done;

  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  a_no_item_from_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!st_valid && !(m_axis_tvalid && !m_axis_tready)) |=> !m_axis_tvalid)
    else $error("result item without a byte behind it");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid && !m_axis_tvalid) |-> take)
    else $error("parser holds a byte with a free result register");

endmodule
